>>> design/apes_pkg.sv
// Package for the acceleration peak-envelope sonifier.
// Payload structs, register indexes, sequencer states and command/status types.
// No dependencies; every other design file refers to it by scoped names.
package apes_pkg;

    localparam int NUM_AXES   = 3;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int ABS_W      = 16;   // |high - baseline| always fits 16 bits unsigned
    localparam int SUM_W      = 34;   // sum of three 32-bit squares
    localparam int ROOT_W     = 17;   // isqrt of a 34-bit value
    localparam int REM_W      = 18;   // root remainder never exceeds 2 * root
    localparam int PROD_W     = 33;   // gain (16) times root (17)
    localparam int STEP_W     = 5;

    localparam logic signed [SAMPLE_W-1:0] ENV_HIGH_START = -16'sd8192;
    localparam logic signed [SAMPLE_W-1:0] ENV_LOW_START  = 16'sd8192;
    localparam logic [7:0]  DAC_CENTRE = 8'd128;
    localparam logic [7:0]  DAC_MAX    = 8'd255;
    localparam logic [15:0] GAIN_RESET = 16'd100;
    localparam logic [7:0]  SPC_RESET  = 8'd20;
    localparam logic [7:0]  CPB_RESET  = 8'd20;

    // sequencer step limits
    localparam logic [STEP_W-1:0] SQ_LAST   = 5'd3;
    localparam logic [STEP_W-1:0] ROOT_LAST = 5'd16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPC     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CPB     = 8'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
    } in_t;

    typedef struct packed {
        logic [7:0]                 dac_level;
        logic                       column_done;
        logic                       baseline_updated;
        logic signed [SAMPLE_W-1:0] high_x;
        logic signed [SAMPLE_W-1:0] low_x;
        logic signed [SAMPLE_W-1:0] high_y;
        logic signed [SAMPLE_W-1:0] low_y;
        logic signed [SAMPLE_W-1:0] high_z;
        logic signed [SAMPLE_W-1:0] low_z;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABS_SQ,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_SCALE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       load;       // capture sample, update envelope
        logic       absq;       // register |high - baseline| of one axis
        logic       acc;        // accumulate square of registered deviation
        logic [1:0] axis;
        logic       root_init;
        logic       root_step;
        logic       scale;
        logic       emit;       // load result register, commit column state
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

>>> design/accel_peak_envelope_sonifier_core.sv
// After an input transfer the core steps through the square states, root setup,
// the 17-step digit-by-digit square root, a scaling state and the emit state, which
// waits while the result register is still full. The next sample is taken only after
// emit, so a new sample is not accepted before the last one is through.
// The result register holds a finished item while the next one is taken in.
// Reset (aresetn, synchronous, active low) restores config defaults, envelope
// -2 g / +2 g, baseline zero and both counters zero.
module accel_peak_envelope_sonifier_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  apes_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output apes_pkg::out_t                  m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [apes_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [apes_pkg::CFG_DATA_W-1:0] cfg_data
);

    apes_pkg::cmd_t    cmd;
    apes_pkg::status_t status;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    apes_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    apes_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

>>> design/apes_ctrl.sv
// Sequencer for the sonifier: walks squares, root iterations, scaling and emit.
// Depends on apes_pkg; drives apes_datapath through cmd_t, reads status_t.
module apes_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  apes_pkg::status_t status,
    output apes_pkg::cmd_t   cmd
);

    apes_pkg::state_t state_reg, state_next;
    logic [apes_pkg::STEP_W-1:0] step_reg, step_next;

    // state and step registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= apes_pkg::ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            apes_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = apes_pkg::ST_ABS_SQ;
                    step_next  = '0;
                end
            end
            apes_pkg::ST_ABS_SQ: begin
                if (step_reg == apes_pkg::SQ_LAST) begin
                    state_next = apes_pkg::ST_ROOT_INIT;
                    step_next  = '0;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            apes_pkg::ST_ROOT_INIT: begin
                state_next = apes_pkg::ST_ROOT;
                step_next  = '0;
            end
            apes_pkg::ST_ROOT: begin
                if (step_reg == apes_pkg::ROOT_LAST) begin
                    state_next = apes_pkg::ST_SCALE;
                    step_next  = '0;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            apes_pkg::ST_SCALE: begin
                state_next = apes_pkg::ST_EMIT;
            end
            apes_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    state_next = apes_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = apes_pkg::ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    // command outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            apes_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            apes_pkg::ST_ABS_SQ: begin
                cmd.absq = (step_reg != apes_pkg::SQ_LAST);
                cmd.axis = step_reg[1:0];
                cmd.acc  = (step_reg != '0);
            end
            apes_pkg::ST_ROOT_INIT: begin
                cmd.root_init = 1'b1;
            end
            apes_pkg::ST_ROOT: begin
                cmd.root_step = 1'b1;
            end
            apes_pkg::ST_SCALE: begin
                cmd.scale = 1'b1;
            end
            apes_pkg::ST_EMIT: begin
                cmd.emit = status.out_free;
            end
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

    // a transfer in always starts the square sequence
    a_load_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == apes_pkg::ST_ABS_SQ && step_reg == '0))
        else $error("transfer in did not start the square sequence");

    // square sequence never runs past its last step
    a_sq_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == apes_pkg::ST_ABS_SQ) |-> (step_reg <= apes_pkg::SQ_LAST))
        else $error("square step counter out of range");

    // root iterations end in the scaling cycle
    a_root_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == apes_pkg::ST_ROOT && step_reg == apes_pkg::ROOT_LAST)
        |=> (state_reg == apes_pkg::ST_SCALE))
        else $error("root sequence did not hand over to scaling");

endmodule

>>> design/apes_datapath.sv
// Datapath for the sonifier: envelope state, config registers, squares,
// digit-by-digit square root, gain scaling and the result register.
// Depends on apes_pkg; controlled by apes_ctrl through cmd_t.
module apes_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  apes_pkg::in_t                     s_data,
    input  logic                              cfg_valid,
    input  logic [apes_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [apes_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output apes_pkg::out_t                    m_data,
    input  apes_pkg::cmd_t                    cmd,
    output apes_pkg::status_t                 status
);

    localparam int W = apes_pkg::SAMPLE_W;

    logic [15:0] gain_reg;
    logic [7:0]  spc_reg;
    logic [7:0]  cpb_reg;

    logic signed [W-1:0] column_high_reg [apes_pkg::NUM_AXES];
    logic signed [W-1:0] column_low_reg  [apes_pkg::NUM_AXES];
    logic signed [W-1:0] baseline_reg    [apes_pkg::NUM_AXES];
    logic [7:0] sample_count_reg;
    logic [7:0] column_count_reg;

    logic [apes_pkg::ABS_W-1:0]  abs_reg;
    logic [apes_pkg::SUM_W-1:0]  sum_reg;
    logic [apes_pkg::SUM_W-1:0]  rad_reg;
    logic [apes_pkg::REM_W-1:0]  rem_reg;
    logic [apes_pkg::ROOT_W-1:0] root_reg;
    logic [apes_pkg::PROD_W-1:0] prod_reg;

    logic           m_valid_reg;
    apes_pkg::out_t m_data_reg;

    logic signed [W-1:0] sample [apes_pkg::NUM_AXES];
    assign sample[0] = s_data.accel_x;
    assign sample[1] = s_data.accel_y;
    assign sample[2] = s_data.accel_z;

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= apes_pkg::GAIN_RESET;
            spc_reg  <= apes_pkg::SPC_RESET;
            cpb_reg  <= apes_pkg::CPB_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                apes_pkg::REG_GAIN: gain_reg <= cfg_data;
                apes_pkg::REG_SPC:  spc_reg  <= cfg_data[7:0];
                apes_pkg::REG_CPB:  cpb_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // deviation of the selected axis
    logic signed [W:0] dev;
    logic [W:0]        dev_mag;
    always_comb begin
        dev     = {column_high_reg[cmd.axis][W-1], column_high_reg[cmd.axis]}
                - {baseline_reg[cmd.axis][W-1], baseline_reg[cmd.axis]};
        dev_mag = dev[W] ? (~dev + 1'b1) : dev;
    end

    // one root iteration: bring down two radicand bits, try root*4+1
    logic [apes_pkg::REM_W+1:0] rem_shift;
    logic [apes_pkg::REM_W+1:0] trial;
    logic                       take;
    logic [apes_pkg::REM_W+1:0] rem_diff;
    always_comb begin
        rem_shift = {rem_reg, rad_reg[apes_pkg::SUM_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        take      = (rem_shift >= trial);
        rem_diff  = rem_shift - trial;
    end

    // column close decisions, taken at emit
    logic [8:0] sample_next;
    logic [8:0] column_next;
    logic       col_close;
    logic       base_reload;
    logic [27:0] level_wide;
    logic [7:0]  level;
    always_comb begin
        sample_next = {1'b0, sample_count_reg} + 9'd1;
        column_next = {1'b0, column_count_reg} + 9'd1;
        col_close   = (sample_next >= {1'b0, spc_reg});
        base_reload = col_close && (column_next >= {1'b0, cpb_reg});
        level_wide  = prod_reg[apes_pkg::PROD_W-1:5];
        if (level_wide > 28'd127) begin
            level = apes_pkg::DAC_MAX;
        end else begin
            level = apes_pkg::DAC_CENTRE + level_wide[7:0];
        end
    end

    // result word for the emit cycle; envelope fields only on a close
    apes_pkg::out_t m_data_next;
    always_comb begin
        m_data_next                  = '0;
        m_data_next.dac_level        = level;
        m_data_next.column_done      = col_close;
        m_data_next.baseline_updated = base_reload;
        if (col_close) begin
            m_data_next.high_x = column_high_reg[0];
            m_data_next.low_x  = column_low_reg[0];
            m_data_next.high_y = column_high_reg[1];
            m_data_next.low_y  = column_low_reg[1];
            m_data_next.high_z = column_high_reg[2];
            m_data_next.low_z  = column_low_reg[2];
        end
    end

    // envelope, baseline and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < apes_pkg::NUM_AXES; i++) begin
                column_high_reg[i] <= apes_pkg::ENV_HIGH_START;
                column_low_reg[i]  <= apes_pkg::ENV_LOW_START;
                baseline_reg[i]    <= '0;
            end
            sample_count_reg <= '0;
            column_count_reg <= '0;
        end else if (cmd.load) begin
            for (int i = 0; i < apes_pkg::NUM_AXES; i++) begin
                if (sample[i] > column_high_reg[i]) column_high_reg[i] <= sample[i];
                if (sample[i] < column_low_reg[i])  column_low_reg[i]  <= sample[i];
            end
        end else if (cmd.emit) begin
            if (col_close) begin
                sample_count_reg <= '0;
                for (int i = 0; i < apes_pkg::NUM_AXES; i++) begin
                    column_high_reg[i] <= apes_pkg::ENV_HIGH_START;
                    column_low_reg[i]  <= apes_pkg::ENV_LOW_START;
                end
                if (base_reload) begin
                    column_count_reg <= '0;
                    for (int i = 0; i < apes_pkg::NUM_AXES; i++) begin
                        baseline_reg[i] <= W'(({column_high_reg[i][W-1], column_high_reg[i]}
                                            + {column_low_reg[i][W-1], column_low_reg[i]})
                                            >>> 1);
                    end
                end else begin
                    column_count_reg <= column_next[7:0];
                end
            end else begin
                sample_count_reg <= sample_next[7:0];
            end
        end
    end

    // squares, root and scaling
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sum_reg <= '0;
        end else if (cmd.acc) begin
            sum_reg <= sum_reg + {2'b00, {16'd0, abs_reg} * {16'd0, abs_reg}};
        end
        if (cmd.absq) begin
            abs_reg <= dev_mag[apes_pkg::ABS_W-1:0];
        end
        if (cmd.root_init) begin
            rad_reg  <= sum_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.root_step) begin
            rad_reg <= {rad_reg[apes_pkg::SUM_W-3:0], 2'b00};
            if (take) begin
                rem_reg  <= rem_diff[apes_pkg::REM_W-1:0];
                root_reg <= {root_reg[apes_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_shift[apes_pkg::REM_W-1:0];
                root_reg <= {root_reg[apes_pkg::ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.scale) begin
            prod_reg <= {17'd0, gain_reg} * {16'd0, root_reg};
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= m_data_next;
        end
    end

    // a closing emit restarts the column at -2 g / +2 g
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && col_close) |=> (column_high_reg[0] == apes_pkg::ENV_HIGH_START
                                     && column_low_reg[2] == apes_pkg::ENV_LOW_START))
        else $error("column envelope not restarted after close");

    // the axis-0 high never falls below its start value, nor the low rises above its own
    a_high_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (column_high_reg[0] >= apes_pkg::ENV_HIGH_START)
        && (column_low_reg[0] <= apes_pkg::ENV_LOW_START))
        else $error("envelope crossed its start value");

    // a baseline reload only comes with a closed column
    a_reload_needs_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.baseline_updated) |-> m_data_reg.column_done)
        else $error("baseline reload without column close");

endmodule
